@@ design/sks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_pkg
// Shared constants, types and the Salsa20 quarter-round helpers.
// ----------------------------------------------------------------------------
package sks_pkg;

	localparam int unsigned DefRounds   = 20;
	localparam int unsigned DefKeyBytes = 32;
	localparam int unsigned CfgIdxW     = 3;
	localparam int unsigned CfgDataW    = 64;
	localparam int unsigned QueueDepth  = 2;

	localparam logic [CfgIdxW-1:0] REG_KEY_0     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY_1     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY_2     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY_3     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_NONCE_0   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_NONCE_1   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_NONCE_2   = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_NONCE_LEN = 3'd7;

	localparam logic [31:0] SIGMA_0 = 32'h61707865;
	localparam logic [31:0] SIGMA_1 = 32'h3020646E;
	localparam logic [31:0] SIGMA_2 = 32'h79622D30;
	localparam logic [31:0] SIGMA_3 = 32'h6B206574;

	typedef logic [15:0][31:0] state_t;

	// Control between the top level and the core.
	typedef struct packed {
		logic start;   // compute a block
		logic hsalsa;  // derive subkey instead of keystream
	} core_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic state_t quarter(input state_t w, input int unsigned a,
		input int unsigned b, input int unsigned c, input int unsigned d);
		state_t r;
		r = w;
		r[b] = r[b] ^ rotl(r[a] + r[d], 7);
		r[c] = r[c] ^ rotl(r[b] + r[a], 9);
		r[d] = r[d] ^ rotl(r[c] + r[b], 13);
		r[a] = r[a] ^ rotl(r[d] + r[c], 18);
		return r;
	endfunction

	// One half-round: column round when odd is 0, row round otherwise.
	function automatic state_t half_round(input state_t w, input logic odd);
		state_t r;
		r = w;
		if (!odd) begin
			r = quarter(r, 0, 4, 8, 12);
			r = quarter(r, 5, 9, 13, 1);
			r = quarter(r, 10, 14, 2, 6);
			r = quarter(r, 15, 3, 7, 11);
		end else begin
			r = quarter(r, 0, 1, 2, 3);
			r = quarter(r, 5, 6, 7, 4);
			r = quarter(r, 10, 11, 8, 9);
			r = quarter(r, 15, 12, 13, 14);
		end
		return r;
	endfunction

endpackage

@@ design/sks_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_core
// Iterative Salsa20 core: one half-round per cycle, then the feed-forward add (skipped for HSalsa).
// ----------------------------------------------------------------------------
module sks_core #(
	parameter int unsigned ROUNDS = sks_pkg::DefRounds
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sks_pkg::core_req_t  req,
	input  sks_pkg::state_t     init,
	output sks_pkg::core_stat_t stat,
	output sks_pkg::state_t     result
);
	localparam int unsigned EffRounds = (ROUNDS == 0) ? 20 : ROUNDS;
	localparam int unsigned CntW = $clog2(EffRounds + 1);

	sks_pkg::state_t w_q, in_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q, hs_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			hs_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				hs_q   <= req.hsalsa;
			end else if (busy_q) begin
				if (cnt_q == CntW'(EffRounds - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			w_q  <= init;
			in_q <= init;
		end else if (busy_q) begin
			w_q <= sks_pkg::half_round(w_q, cnt_q[0]);
		end
	end

	// HSalsa returns the raw permutation, Salsa20 adds the input back.
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			result[k] = hs_q ? w_q[k] : w_q[k] + in_q[k];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ design/sks_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_front
// Input side: takes data bytes into a short queue.
// ----------------------------------------------------------------------------
module sks_front (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       flush,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_data,
	output logic       q_valid,
	input  logic       q_pop,
	output logic [7:0] q_data
);
	localparam int unsigned D = sks_pkg::QueueDepth;
	localparam int unsigned PW = $clog2(D);

	logic [D-1:0][7:0] mem_q;
	logic [PW-1:0]     wp_q, rp_q;
	logic [PW:0]       cnt_q;
	logic              push;

	assign in_ready = (cnt_q != (PW+1)'(D));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_data   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else if (flush) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

endmodule

@@ design/salsa20_keystream_xor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salsa20_keystream_xor_core
// Salsa20 / XSalsa20 keystream XOR, one byte per request.
// ----------------------------------------------------------------------------
// Channel   Signals                            Direction
// in        in_valid, in_ready, data_byte      request in
// out       out_valid, out_ready, out_byte     request out
// cfg       cfg_we, cfg_index, cfg_data        write only
//
// Bytes pass without waiting while the current keystream block lasts,
// unless out_ready holds them back. The first byte of each 64-byte block
// waits for the iterative core (one half-round per cycle) to produce the
// next block. A configuration write with an extended nonce runs the HSalsa
// pass first; bytes wait meanwhile. Reset loads the default state.
// ----------------------------------------------------------------------------
module salsa20_keystream_xor_core #(
	parameter int unsigned ROUNDS    = sks_pkg::DefRounds,
	parameter int unsigned KEY_BYTES = sks_pkg::DefKeyBytes
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	input  logic                          cfg_we,
	input  logic [sks_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [sks_pkg::CfgDataW-1:0]  cfg_data
);
	localparam int unsigned EffKey = (KEY_BYTES > 32) ? 32 : KEY_BYTES;
	localparam logic [31:0] Sig1 = sks_pkg::SIGMA_1 + ((32'(EffKey / 10)) << 24);
	localparam logic [31:0] Sig2 = sks_pkg::SIGMA_2 + 32'(EffKey % 10);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DERIVE = 4'b0010,
		ST_GEN    = 4'b0100,
		ST_WAIT   = 4'b1000
	} st_t;

	st_t st_q;
	logic [3:0][63:0] key_q;
	logic [2:0][63:0] nonce_q;
	logic [4:0]       nlen_q;
	logic [7:0][31:0] subkey_q;
	sks_pkg::state_t  block_q;
	logic [6:0]       pos_q;
	logic [63:0]      ctr_q;
	logic             derive_pend_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             core_is_hs_q;

	logic [4:0]       nlen;
	logic             ext;
	logic [255:0]     key_bits;
	logic [191:0]     nonce_bits;
	logic [7:0][31:0] key_words;
	logic [5:0][31:0] nonce_words;
	sks_pkg::state_t  core_init, core_res;
	sks_pkg::core_req_t  creq;
	sks_pkg::core_stat_t cstat;
	logic             q_valid, q_pop;
	logic [7:0]       q_data;
	logic             cfg_hit;
	logic [7:0]       ks;

	assign cfg_hit = cfg_we;
	assign nlen = (nlen_q > 5'd24) ? 5'd24 : nlen_q;
	assign ext  = nlen > 5'd8;

	always_comb begin
		for (int b = 0; b < 32; b++) begin
			key_bits[8*b +: 8] = (b < EffKey) ? key_q[b/8][8*(b%8) +: 8] : 8'h00;
		end
		for (int b = 0; b < 24; b++) begin
			nonce_bits[8*b +: 8] = (5'(b) < nlen) ? nonce_q[b/8][8*(b%8) +: 8] : 8'h00;
		end
		for (int k = 0; k < 4; k++) begin
			key_words[k] = key_bits[32*k +: 32];
			key_words[4+k] = (EffKey > 16) ? key_bits[128 + 32*k +: 32] : key_bits[32*k +: 32];
		end
		for (int m = 0; m < 6; m++) begin
			nonce_words[m] = nonce_bits[32*m +: 32];
		end
	end

	always_comb begin
		core_init[0]  = sks_pkg::SIGMA_0;
		core_init[5]  = Sig1;
		core_init[10] = Sig2;
		core_init[15] = sks_pkg::SIGMA_3;
		if (st_q == ST_DERIVE) begin
			for (int k = 0; k < 4; k++) begin
				core_init[1+k]  = key_words[k];
				core_init[11+k] = key_words[4+k];
				core_init[6+k]  = nonce_words[k];
			end
		end else begin
			for (int k = 0; k < 4; k++) begin
				core_init[1+k]  = subkey_q[k];
				core_init[11+k] = subkey_q[4+k];
			end
			core_init[6] = ext ? nonce_words[4] : nonce_words[0];
			core_init[7] = ext ? nonce_words[5] : nonce_words[1];
			core_init[8] = ctr_q[31:0];
			core_init[9] = ctr_q[63:32];
		end
	end

	assign creq.start  = (st_q == ST_DERIVE || st_q == ST_GEN) && !cstat.busy && !cstat.done;
	assign creq.hsalsa = (st_q == ST_DERIVE);

	sks_core #(.ROUNDS(ROUNDS)) u_core (
		.clk(clk), .arst_n(arst_n), .req(creq), .init(core_init),
		.stat(cstat), .result(core_res)
	);

	sks_front u_front (
		.clk(clk), .arst_n(arst_n), .flush(1'b0),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(data_byte),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	assign ks = block_q[pos_q[5:2]][8*pos_q[1:0] +: 8];
	assign q_pop = (st_q == ST_IDLE) && !derive_pend_q && q_valid && !pos_q[6]
		&& (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			key_q         <= '0;
			nonce_q       <= '0;
			nlen_q        <= 5'd8;
			subkey_q      <= '0;
			pos_q         <= 7'd64;
			ctr_q         <= '0;
			derive_pend_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (q_pop) begin
				out_valid_q <= 1'b1;
				pos_q       <= pos_q + 7'd1;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (derive_pend_q) begin
						derive_pend_q <= 1'b0;
						if (ext) st_q <= ST_DERIVE;
						else subkey_q <= key_words;
					end else if (pos_q[6] && q_valid) begin
						st_q <= ST_GEN;
					end
				end
				ST_DERIVE, ST_GEN: begin
					if (creq.start) st_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (cstat.done) begin
						st_q <= ST_IDLE;
						if (core_is_hs_q) begin
							subkey_q <= {core_res[9], core_res[8], core_res[7], core_res[6],
								core_res[15], core_res[10], core_res[5], core_res[0]};
						end else begin
							pos_q <= 7'd0;
							ctr_q <= ctr_q + 64'd1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (cfg_hit) begin
				unique case (cfg_index)
					sks_pkg::REG_KEY_0:     key_q[0] <= cfg_data;
					sks_pkg::REG_KEY_1:     key_q[1] <= cfg_data;
					sks_pkg::REG_KEY_2:     key_q[2] <= cfg_data;
					sks_pkg::REG_KEY_3:     key_q[3] <= cfg_data;
					sks_pkg::REG_NONCE_0:   nonce_q[0] <= cfg_data;
					sks_pkg::REG_NONCE_1:   nonce_q[1] <= cfg_data;
					sks_pkg::REG_NONCE_2:   nonce_q[2] <= cfg_data;
					sks_pkg::REG_NONCE_LEN: nlen_q <= cfg_data[4:0];
					default: ;
				endcase
				derive_pend_q <= 1'b1;
				ctr_q         <= '0;
				pos_q         <= 7'd64;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_is_hs_q <= 1'b0;
		end else if (creq.start) begin
			core_is_hs_q <= creq.hsalsa;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_WAIT && cstat.done && !core_is_hs_q) block_q <= core_res;
		if (q_pop) out_byte_q <= q_data ^ ks;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

endmodule
